[rtl/core/ab4_pkg.sv]
// Shared types and constants for the fourth-order Adams-Bashforth vector integrator.
// Used by the top level, the per-component datapath and the port checker.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ab4_pkg;

	// Field widths and defaults.
	localparam int IDX_W          = 10;
	localparam int DATA_W         = 32;
	localparam int NUM_POINTS_DEF = 1024;
	localparam logic [DATA_W-1:0] DT_RESET = 32'd16777;

	// Stream payload layout.
	localparam int S_TDATA_W = 208;
	localparam int M_TDATA_W = 112;
	localparam int M_TUSER_W = 1;

	// Pipeline depth: memory read, seven arithmetic stages, output register.
	localparam int NUM_STAGES = 9;

	// Weighted derivative sum and its magnitude.
	localparam int ACC_W     = 40;
	localparam int MAG_W     = 39;
	localparam int MAG_SPLIT = 20;
	localparam logic signed [ACC_W-1:0] COEF_DY = 40'sd55;
	localparam logic signed [ACC_W-1:0] COEF_H1 = 40'sd59;
	localparam logic signed [ACC_W-1:0] COEF_H2 = 40'sd37;
	localparam logic signed [ACC_W-1:0] COEF_H3 = 40'sd9;

	// Partial products of dt times the magnitude.
	localparam int PLO_W = DATA_W + MAG_SPLIT;
	localparam int PHI_W = DATA_W + MAG_W - MAG_SPLIT;
	localparam int SUM_W = PHI_W + MAG_SPLIT;

	// Divisor 24 * 2^24 = 3 * 2^27: round, shift by 27, then divide by three.
	localparam int TRUNC_SH = 27;
	localparam int T_W      = SUM_W - TRUNC_SH;
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'd3 << (TRUNC_SH - 1));

	// Divide by three: T = Th * 2^22 + Tl and 2^22 = 3 * 1398101 + 1.
	localparam int HALF_W    = 22;
	localparam int DIV3_HI_W = 21;
	localparam logic [DIV3_HI_W-1:0] DIV3_HI = 21'd1398101;
	localparam int A_W       = HALF_W + DIV3_HI_W;
	localparam int U_W       = HALF_W + 1;
	localparam int RECIP_W   = 24;
	localparam int RECIP_SH  = 25;
	localparam logic [RECIP_W-1:0] DIV3_RECIP = 24'd11184811;
	localparam int B_W       = U_W + RECIP_W;
	localparam int QLO_W     = B_W - RECIP_SH;

	// Final add and clamp.
	localparam int R_W = T_W + 2;
	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef logic [DATA_W-1:0] word_t;
	typedef word_t [2:0] vec3_t;

	typedef struct packed {
		vec3_t oldest;
		vec3_t middle;
		vec3_t newest;
	} hist_row_t;

endpackage

`default_nettype wire

[rtl/core/ab4_comp.sv]
// One vector component of the integrator: weighted sum, scale by dt/24, round, add and clamp.
// Eight register stages driven by the stage enables of the top level; depends on ab4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ab4_comp
	import ab4_pkg::*;
(
	input  logic                     clk,
	input  logic [NUM_STAGES:2]      stage_en,
	input  logic [DATA_W-1:0]        dt,
	input  logic signed [DATA_W-1:0] y_in,
	input  logic signed [DATA_W-1:0] dy_in,
	input  logic signed [DATA_W-1:0] h1_in,
	input  logic signed [DATA_W-1:0] h2_in,
	input  logic signed [DATA_W-1:0] h3_in,
	output logic signed [DATA_W-1:0] result,
	output logic                     clip
);

	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [DATA_W-1:0] y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8;
	logic                     neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [MAG_W-1:0]         mag_s3;
	logic [PLO_W-1:0]         plo_s4;
	logic [PHI_W-1:0]         phi_s4;
	logic [T_W-1:0]           t_s5;
	logic [A_W-1:0]           a_s6, a_s7;
	logic [U_W-1:0]           u_s6;
	logic [QLO_W-1:0]         qlo_s7;
	logic [T_W-1:0]           q_s8;

	logic signed [ACC_W-1:0]  acc_next;
	logic [MAG_W-1:0]         mag_next;
	logic [SUM_W-1:0]         sum_next;
	logic [B_W-1:0]           recip_prod;
	logic signed [R_W-1:0]    r_next;
	logic signed [R_W-1:0]    q_ext;
	logic                     ovf;

	always_comb begin
		acc_next = ACC_W'(dy_in) * COEF_DY - ACC_W'(h1_in) * COEF_H1
			+ ACC_W'(h2_in) * COEF_H2 - ACC_W'(h3_in) * COEF_H3;
		mag_next = acc_s2[ACC_W-1] ? MAG_W'(-acc_s2) : MAG_W'(acc_s2);
		sum_next = {phi_s4, {MAG_SPLIT{1'b0}}} + SUM_W'(plo_s4) + ROUND_BIAS;
		recip_prod = B_W'(u_s6) * B_W'(DIV3_RECIP);
		q_ext = $signed({2'b00, q_s8});
		r_next = neg_s8 ? (R_W'(y_s8) - q_ext) : (R_W'(y_s8) + q_ext);
		ovf = (r_next[R_W-1:DATA_W-1] != {(R_W-DATA_W+1){1'b0}})
			&& (r_next[R_W-1:DATA_W-1] != {(R_W-DATA_W+1){1'b1}});
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			acc_s2 <= acc_next;
			y_s2 <= y_in;
		end
		if (stage_en[3]) begin
			neg_s3 <= acc_s2[ACC_W-1];
			mag_s3 <= mag_next;
			y_s3 <= y_s2;
		end
		if (stage_en[4]) begin
			plo_s4 <= PLO_W'(dt) * PLO_W'(mag_s3[MAG_SPLIT-1:0]);
			phi_s4 <= PHI_W'(dt) * PHI_W'(mag_s3[MAG_W-1:MAG_SPLIT]);
			neg_s4 <= neg_s3;
			y_s4 <= y_s3;
		end
		if (stage_en[5]) begin
			t_s5 <= sum_next[SUM_W-1:TRUNC_SH];
			neg_s5 <= neg_s4;
			y_s5 <= y_s4;
		end
		if (stage_en[6]) begin
			a_s6 <= A_W'(t_s5[T_W-1:HALF_W]) * A_W'(DIV3_HI);
			u_s6 <= U_W'(t_s5[T_W-1:HALF_W]) + U_W'(t_s5[HALF_W-1:0]);
			neg_s6 <= neg_s5;
			y_s6 <= y_s5;
		end
		if (stage_en[7]) begin
			a_s7 <= a_s6;
			qlo_s7 <= recip_prod[B_W-1:RECIP_SH];
			neg_s7 <= neg_s6;
			y_s7 <= y_s6;
		end
		if (stage_en[8]) begin
			q_s8 <= T_W'(a_s7) + T_W'(qlo_s7);
			neg_s8 <= neg_s7;
			y_s8 <= y_s7;
		end
		if (stage_en[9]) begin
			clip <= ovf;
			if (!ovf) begin
				result <= r_next[DATA_W-1:0];
			end else if (r_next[R_W-1]) begin
				result <= SAT_MIN;
			end else begin
				result <= SAT_MAX;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/adams_bashforth4_vector_step.sv]
// An accepted request passes through one memory read stage, seven arithmetic stages and the
// output register, nine register stages in all, before it shows on m_tvalid. Throughput: one
// request per cycle while the output is not stalled and no clearing pass runs.
// Reset: arst_n clears control state and dt_step to 16777; then a clearing pass over all
// min(NUM_POINTS, 1024) rows zeroes the history memory while s_tready stays low.
// Configuration writes are taken in every cycle, cfg_ready is tied high.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the Adams-Bashforth vector step: history memory, forwarding, stage control.
// Depends on ab4_pkg and ab4_comp.
module adams_bashforth4_vector_step
	import ab4_pkg::*;
#(
	parameter int NUM_POINTS = NUM_POINTS_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DATA_W-1:0]     cfg_data,    // dt_step, unsigned Q8.24

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// From bit 0: point_index[10], value_x, value_y, value_z, rate_x, rate_y, rate_z
	// (32 each), zero pad.
	input  logic [S_TDATA_W-1:0]  s_tdata,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// From bit 0: out_index[10], new_x, new_y, new_z (32 each), zero pad.
	output logic [M_TDATA_W-1:0]  m_tdata,
	// Bit 0: saturated.
	output logic [M_TUSER_W-1:0]  m_tuser
);

	// The memory only needs as many rows as the index field can address.
	localparam int DEPTH  = (NUM_POINTS < (2 ** IDX_W)) ? NUM_POINTS : (2 ** IDX_W);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam int M_PAD  = M_TDATA_W - IDX_W - 3 * DATA_W;

	// Configuration register. cfg_ready is always high because the register
	// write never has to wait.
	logic [DATA_W-1:0] dt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
		end else if (cfg_valid) begin
			dt_q <= cfg_data;
		end
	end

	// Clearing pass. The history memory has no per-row valid bits, so after
	// reset every row is written with zero before the first request is taken.
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage control. Each stage loads when it is empty or its successor
	// loads, so bubbles collapse and a stall at the output only backs up as
	// far as the pipeline is full.
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] stage_en;

	always_comb begin
		stage_en[NUM_STAGES] = !vld_q[NUM_STAGES] || m_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	assign s_tready = stage_en[1] && !clearing_q;
	assign m_tvalid = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				vld_q[1] <= s_tvalid && s_tready;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Input unpacking.
	logic [IDX_W-1:0] in_idx;
	vec3_t            in_val;
	vec3_t            in_rate;
	logic             in_ok;

	always_comb begin
		in_idx = s_tdata[IDX_W-1:0];
		for (int c = 0; c < 3; c++) begin
			in_val[c]  = s_tdata[IDX_W + DATA_W * c +: DATA_W];
			in_rate[c] = s_tdata[IDX_W + DATA_W * (3 + c) +: DATA_W];
		end
		in_ok = (32'(in_idx) < 32'(NUM_POINTS));
	end

	// Stage 1: history row read. The row written by the request that leaves
	// stage 1 in the same cycle is not yet visible in the memory read, so it
	// is captured alongside and takes precedence when the index matches.
	logic [IDX_W-1:0] idx_s1;
	logic             ok_s1;
	vec3_t            val_s1;
	vec3_t            rate_s1;
	hist_row_t        rd_row_s1;
	logic             fwd_s1;
	hist_row_t        fwd_row_s1;

	hist_row_t        eff_row;
	hist_row_t        upd_row;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	hist_row_t        wr_row;
	logic             s1_commit;

	hist_row_t        hist_mem_q [DEPTH];

	always_comb begin
		if (!ok_s1) begin
			eff_row = '0;
		end else if (fwd_s1) begin
			eff_row = fwd_row_s1;
		end else begin
			eff_row = rd_row_s1;
		end
		// Shift the history: the current derivative becomes the newest entry.
		upd_row.newest = rate_s1;
		upd_row.middle = eff_row.newest;
		upd_row.oldest = eff_row.middle;

		// The row is written as the request moves on to stage 2.
		s1_commit = vld_q[1] && ok_s1 && stage_en[2];
		wr_en     = clearing_q || s1_commit;
		wr_addr   = clearing_q ? clr_addr_q : idx_s1[ADDR_W-1:0];
		wr_row    = clearing_q ? hist_row_t'('0) : upd_row;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem_q[wr_addr] <= wr_row;
		end
		if (stage_en[1]) begin
			rd_row_s1 <= hist_mem_q[in_idx[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			idx_s1     <= in_idx;
			ok_s1      <= in_ok;
			val_s1     <= in_val;
			rate_s1    <= in_rate;
			fwd_s1     <= s1_commit && (idx_s1 == in_idx);
			fwd_row_s1 <= upd_row;
		end
	end

	// The index rides along with the arithmetic.
	logic [IDX_W-1:0] idx_dly_s [2:NUM_STAGES];

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			idx_dly_s[2] <= idx_s1;
		end
		for (int k = 3; k <= NUM_STAGES; k++) begin
			if (stage_en[k]) begin
				idx_dly_s[k] <= idx_dly_s[k-1];
			end
		end
	end

	// Per-component datapath, stages 2 through 9.
	word_t new_val [3];
	logic  [2:0] clip;

	for (genvar c = 0; c < 3; c++) begin : g_comp
		ab4_comp u_comp (
			.clk      (clk),
			.stage_en (stage_en[NUM_STAGES:2]),
			.dt       (dt_q),
			.y_in     (val_s1[c]),
			.dy_in    (rate_s1[c]),
			.h1_in    (eff_row.newest[c]),
			.h2_in    (eff_row.middle[c]),
			.h3_in    (eff_row.oldest[c]),
			.result   (new_val[c]),
			.clip     (clip[c])
		);
	end

	assign m_tdata = {{M_PAD{1'b0}}, new_val[2], new_val[1], new_val[0], idx_dly_s[NUM_STAGES]};
	assign m_tuser = M_TUSER_W'(|clip);

endmodule

`default_nettype wire

[rtl/core/ab4_chk.sv]
// Port checker for the Adams-Bashforth vector step, with its bind to the top level.
// Tracks requests in flight from the stream handshakes; depends on ab4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ab4_chk
	import ab4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [M_TUSER_W-1:0] m_tuser
);

	localparam int CNT_W = $clog2(NUM_STAGES + 1) + 1;

	logic [CNT_W-1:0] inflight_q;
	logic             s_acc;
	logic             m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(s_acc) - CNT_W'(m_acc);
		end
	end

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// No more requests in flight than the pipeline has stages.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(NUM_STAGES))
		else $error("more requests in flight than pipeline stages");

	// A result only appears for a request that was taken.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> !m_tvalid)
		else $error("result without a pending request");

	// A full, stalled pipeline takes no new request.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'(NUM_STAGES) && !m_tready |-> !s_tready)
		else $error("request taken while pipeline is full");

endmodule

bind adams_bashforth4_vector_step ab4_chk u_ab4_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
